FILE: design/brf_pkg.sv
`default_nettype none
package brf_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int DIV_CNT_W   = 6;

    typedef logic signed [63:0] q_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
    localparam q_t ONE_Q = q_t'(64'd1 << FRAC_BITS);
    localparam count_t COUNT_MAX = '1;

    localparam logic [1:0] MODE_LOWER = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_VALUE = 2'd2;

    localparam logic [1:0] ST_LOADED    = 2'd0;
    localparam logic [1:0] ST_EVALUATE  = 2'd1;
    localparam logic [1:0] ST_CONVERGED = 2'd2;
    localparam logic [1:0] ST_LIMIT     = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LOWER = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;

    localparam logic [1:0] REG_ABS_TOL   = 2'd0;
    localparam logic [1:0] REG_REL_TOL   = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS = 2'd2;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        q_t      x;
        q_t      y;
    } alu_req_t;

    typedef struct packed {
        logic done;
        q_t   result;
    } alu_rsp_t;

    function automatic logic [63:0] mag(input q_t x);
        return x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    function automatic q_t from_mag(input logic [63:0] u, input logic neg, input logic ovf);
        if (neg)
            return (ovf || u[63]) ? Q_MIN : q_t'(64'd0 - u);
        return (ovf || u[63]) ? Q_MAX : q_t'(u);
    endfunction

    function automatic q_t sadd(input q_t x, input q_t y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic q_t ssub(input q_t x, input q_t y);
        logic signed [64:0] s;
        s = {x[63], x} - {y[63], y};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic q_t sneg(input q_t x);
        return (x == Q_MIN) ? Q_MAX : -x;
    endfunction

    function automatic q_t sabs(input q_t x);
        return x[63] ? sneg(x) : x;
    endfunction

    function automatic q_t half(input q_t x);
        return from_mag(mag(x) >> 1, x[63], 1'b0);
    endfunction

endpackage
`default_nettype wire

FILE: design/brf_channels.sv
`default_nettype none
interface brf_in_if;
    import brf_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    q_t         point;
    q_t         func_value;

    modport source (output valid, output mode, output point, output func_value, input ready);
    modport sink (input valid, input mode, input point, input func_value, output ready);
endinterface

interface brf_out_if;
    import brf_pkg::*;
    logic       valid;
    logic       ready;
    q_t         query_point;
    logic [1:0] status;

    modport source (output valid, output query_point, output status, input ready);
    modport sink (input valid, input query_point, input status, output ready);
endinterface
`default_nettype wire

FILE: design/brf_alu.sv
`default_nettype none
module brf_alu
    import brf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_RND  = 4'b0100,
        A_DIV  = 4'b1000
    } alu_state_t;

    alu_state_t state_reg, state_next;
    logic [63:0]  ux_reg, ux_next, uy_reg, uy_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   idx_reg, idx_next;
    logic [63:0]  rem_reg, rem_next, dvd_reg, dvd_next, quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    q_t           res_reg, res_next;
    logic         done_reg, done_next;

    logic [63:0]  in_ux, in_uy, in_hi;
    logic [63:0]  pp;
    logic [127:0] pp_ext, rnd_sum;
    logic [64:0]  rsh;

    always_comb
    begin
        in_ux   = mag(req.x);
        in_uy   = mag(req.y);
        in_hi   = in_ux >> (64 - FRAC_BITS);
        pp      = 64'(ux_reg[32*idx_reg[0] +: 32]) * 64'(uy_reg[32*idx_reg[1] +: 32]);
        case (2'(idx_reg[0]) + 2'(idx_reg[1]))
            2'd0:    pp_ext = {64'd0, pp};
            2'd1:    pp_ext = {32'd0, pp, 32'd0};
            default: pp_ext = {pp, 64'd0};
        endcase
        rnd_sum = acc_reg + (128'd1 << (FRAC_BITS - 1));
        rsh     = {rem_reg, dvd_reg[63]};

        state_next = state_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    ux_next  = in_ux;
                    uy_next  = in_uy;
                    neg_next = req.x[63] ^ req.y[63];
                    if (req.op == ALU_MUL)
                    begin
                        acc_next   = '0;
                        idx_next   = '0;
                        state_next = A_MUL;
                    end
                    else if (req.y == '0)
                    begin
                        res_next  = (req.x == '0) ? '0 : (req.x[63] ? Q_MIN : Q_MAX);
                        done_next = 1'b1;
                    end
                    else if (in_hi >= in_uy)
                    begin
                        res_next  = from_mag('0, req.x[63] ^ req.y[63], 1'b1);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = in_hi;
                        dvd_next   = in_ux << FRAC_BITS;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                acc_next = acc_reg + pp_ext;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = A_RND;
            end
            A_RND:
            begin
                res_next   = from_mag(rnd_sum[FRAC_BITS +: 64], neg_reg,
                                      |rnd_sum[127 -: (64 - FRAC_BITS)]);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV:
            begin
                // one quotient bit a cycle, restoring
                if (rsh >= {1'b0, uy_reg})
                begin
                    rem_next = 64'(rsh - {1'b0, uy_reg});
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    res_next   = from_mag(quo_next, neg_reg, 1'b0);
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg  <= ux_next;
        uy_reg  <= uy_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

FILE: design/bracketed_root_finder.sv
// Flow: a bound load or an ignored beat goes from idle to the emit step when it is taken,
//   and its result is registered on the output once that register is free. A full inverse
//   quadratic step hands four divisions and ten multiplies to the shared unit.
// Throughput: one beat at a time; the shared multiply/divide unit paces each search step,
//   its division resolving one quotient bit per cycle.
// Reset: rst_n clears the search state asynchronously and loads the default tolerances.
`default_nettype none
module bracketed_root_finder
    import brf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    brf_in_if.sink           in_ch,
    brf_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Sequencer states: one per operation handed to the shared unit, plus the
    // bracket bookkeeping steps around them.
    typedef enum logic [22:0] {
        FS_IDLE  = 23'h000001,
        FS_SWAP  = 23'h000002,
        FS_SETD  = 23'h000004,
        FS_LIMIT = 23'h000008,
        FS_TOL   = 23'h000010,
        FS_CHK   = 23'h000020,
        FS_SQ    = 23'h000040,
        FS_P1    = 23'h000080,
        FS_QQ    = 23'h000100,
        FS_RR    = 23'h000200,
        FS_T1A   = 23'h000400,
        FS_T1B   = 23'h000800,
        FS_T2    = 23'h001000,
        FS_PP    = 23'h002000,
        FS_QA    = 23'h004000,
        FS_QB    = 23'h008000,
        FS_SIGN  = 23'h010000,
        FS_C1    = 23'h020000,
        FS_C2    = 23'h040000,
        FS_C3    = 23'h080000,
        FS_DIVD  = 23'h100000,
        FS_STEP  = 23'h200000,
        FS_EMIT  = 23'h400000
    } fsm_t;

    fsm_t state_reg, state_next;

    // Bracket: a = previous point, b = best, c = contra point.
    q_t a_reg, a_next, fa_reg, fa_next, b_reg, b_next, fb_reg, fb_next;
    q_t c_reg, c_next, fc_reg, fc_next, d_reg, d_next, e_reg, e_next;
    count_t cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic start_reg, start_next;

    // Scratch values of one step.
    q_t m_reg, m_next, tol_reg, tol_next, s_reg, s_next, p_reg, p_next;
    q_t q_reg, q_next, qq_reg, qq_next, r_reg, r_next;
    q_t t1_reg, t1_next, t2_reg, t2_next, saved_reg, saved_next;
    q_t res_pt_reg, res_pt_next;
    logic [1:0] res_st_reg, res_st_next;

    logic out_valid_reg, out_valid_next;
    q_t out_pt_reg, out_pt_next;
    logic [1:0] out_st_reg, out_st_next;

    logic issued_reg, issued_next;
    logic [31:0] abs_tol_reg, rel_tol_reg;
    logic [15:0] max_steps_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic alu_state;
    q_t m2, m3, b_abs;

    brf_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    //------------------------------------------------------------------------
    // Configuration port: zero wait states, writes land on the access phase.
    //------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg   <= 32'd4295;
            rel_tol_reg   <= 32'd1;
            max_steps_reg <= 16'd100;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_ABS_TOL:   abs_tol_reg   <= pwdata;
                REG_REL_TOL:   rel_tol_reg   <= pwdata;
                REG_MAX_STEPS: max_steps_reg <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ABS_TOL:   prdata = abs_tol_reg;
            REG_REL_TOL:   prdata = rel_tol_reg;
            REG_MAX_STEPS: prdata = {16'd0, max_steps_reg};
            default:       prdata = '0;
        endcase
    end

    //------------------------------------------------------------------------
    // Operand selection for the shared multiply/divide unit. Every state that
    // needs the unit issues once, then waits for its done pulse.
    //------------------------------------------------------------------------
    assign m2    = sadd(m_reg, m_reg);
    assign m3    = sadd(m2, m_reg);
    assign b_abs = sabs(b_reg);

    always_comb
    begin
        alu_state   = 1'b1;
        alu_req.op  = ALU_MUL;
        alu_req.x   = '0;
        alu_req.y   = '0;
        case (state_reg)
            FS_TOL:
            begin
                alu_req.x = sadd(b_abs, b_abs);
                alu_req.y = q_t'({32'd0, rel_tol_reg});
            end
            FS_SQ:
            begin
                alu_req.op = ALU_DIV;
                alu_req.x  = fb_reg;
                alu_req.y  = fa_reg;
            end
            FS_P1:
            begin
                alu_req.x = m2;
                alu_req.y = s_reg;
            end
            FS_QQ:
            begin
                alu_req.op = ALU_DIV;
                alu_req.x  = fa_reg;
                alu_req.y  = fc_reg;
            end
            FS_RR:
            begin
                alu_req.op = ALU_DIV;
                alu_req.x  = fb_reg;
                alu_req.y  = fc_reg;
            end
            FS_T1A:
            begin
                alu_req.x = m2;
                alu_req.y = qq_reg;
            end
            FS_T1B:
            begin
                alu_req.x = t1_reg;
                alu_req.y = ssub(qq_reg, r_reg);
            end
            FS_T2:
            begin
                alu_req.x = ssub(b_reg, a_reg);
                alu_req.y = ssub(r_reg, ONE_Q);
            end
            FS_PP:
            begin
                alu_req.x = s_reg;
                alu_req.y = ssub(t1_reg, t2_reg);
            end
            FS_QA:
            begin
                alu_req.x = ssub(qq_reg, ONE_Q);
                alu_req.y = ssub(r_reg, ONE_Q);
            end
            FS_QB:
            begin
                alu_req.x = q_reg;
                alu_req.y = ssub(s_reg, ONE_Q);
            end
            FS_C1:
            begin
                alu_req.x = m3;
                alu_req.y = q_reg;
            end
            FS_C2:
            begin
                alu_req.x = tol_reg;
                alu_req.y = q_reg;
            end
            FS_C3:
            begin
                alu_req.x = half(saved_reg);
                alu_req.y = q_reg;
            end
            FS_DIVD:
            begin
                alu_req.op = ALU_DIV;
                alu_req.x  = p_reg;
                alu_req.y  = q_reg;
            end
            default:
            begin
                alu_state = 1'b0;
            end
        endcase
        alu_req.start = alu_state && !issued_reg;
    end

    assign in_ch.ready = (state_reg == FS_IDLE);

    //------------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        fa_next     = fa_reg;
        b_next      = b_reg;
        fb_next     = fb_reg;
        c_next      = c_reg;
        fc_next     = fc_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        m_next      = m_reg;
        tol_next    = tol_reg;
        s_next      = s_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        qq_next     = qq_reg;
        r_next      = r_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        saved_next  = saved_reg;
        res_pt_next = res_pt_reg;
        res_st_next = res_st_reg;

        issued_next = issued_reg;
        if (alu_req.start)
            issued_next = 1'b1;
        if (alu_rsp.done)
            issued_next = 1'b0;

        // Drain the output register whenever the sink takes the beat.
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pt_next    = out_pt_reg;
        out_st_next    = out_st_reg;

        case (state_reg)
            FS_IDLE:
            begin
                if (in_ch.valid)
                begin
                    res_pt_next = '0;
                    res_st_next = ST_LOADED;
                    state_next  = FS_EMIT;
                    if (in_ch.mode == MODE_LOWER)
                    begin
                        a_next     = in_ch.point;
                        fa_next    = in_ch.func_value;
                        phase_next = PH_LOWER;
                    end
                    else if (in_ch.mode == MODE_UPPER)
                    begin
                        b_next     = in_ch.point;
                        fb_next    = in_ch.func_value;
                        c_next     = a_reg;
                        fc_next    = fa_reg;
                        cnt_next   = count_t'(1);
                        start_next = 1'b1;
                        state_next = FS_SWAP;
                    end
                    else if (in_ch.mode == MODE_VALUE && phase_reg == PH_WAIT)
                    begin
                        fb_next    = in_ch.func_value;
                        start_next = 1'b0;
                        // new value on the same side as c: c takes the old best
                        if ((!in_ch.func_value[63] && in_ch.func_value != '0
                             && !fc_reg[63] && fc_reg != '0)
                            || (in_ch.func_value[63] && fc_reg[63]))
                        begin
                            c_next  = a_reg;
                            fc_next = fa_reg;
                            d_next  = ssub(b_reg, a_reg);
                            e_next  = ssub(b_reg, a_reg);
                        end
                        state_next = FS_SWAP;
                    end
                end
            end
            FS_SWAP:
            begin
                // keep the smaller residual at b
                if (sabs(fc_reg) < sabs(fb_reg))
                begin
                    a_next  = b_reg;
                    fa_next = fb_reg;
                    b_next  = c_reg;
                    fb_next = fc_reg;
                    c_next  = b_reg;
                    fc_next = fb_reg;
                end
                state_next = start_reg ? FS_SETD : FS_LIMIT;
            end
            FS_SETD:
            begin
                d_next     = ssub(b_reg, a_reg);
                e_next     = ssub(b_reg, a_reg);
                state_next = FS_TOL;
            end
            FS_LIMIT:
            begin
                if (cnt_reg >= count_t'(max_steps_reg) || cnt_reg >= COUNT_MAX)
                begin
                    res_pt_next = b_reg;
                    res_st_next = ST_LIMIT;
                    phase_next  = PH_IDLE;
                    state_next  = FS_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = FS_TOL;
                end
            end
            FS_TOL:
            begin
                if (alu_rsp.done)
                begin
                    tol_next   = sadd(alu_rsp.result, q_t'({32'd0, abs_tol_reg}));
                    m_next     = half(ssub(c_reg, b_reg));
                    state_next = FS_CHK;
                end
            end
            FS_CHK:
            begin
                if (sabs(m_reg) <= tol_reg || fb_reg == '0)
                begin
                    res_pt_next = b_reg;
                    res_st_next = ST_CONVERGED;
                    phase_next  = PH_IDLE;
                    state_next  = FS_EMIT;
                end
                else if (sabs(e_reg) < tol_reg || sabs(fa_reg) <= sabs(fb_reg))
                begin
                    d_next     = m_reg;
                    e_next     = m_reg;
                    state_next = FS_STEP;
                end
                else
                begin
                    state_next = FS_SQ;
                end
            end
            FS_SQ:
            begin
                if (alu_rsp.done)
                begin
                    s_next     = alu_rsp.result;
                    state_next = (a_reg == c_reg) ? FS_P1 : FS_QQ;
                end
            end
            FS_P1:
            begin
                if (alu_rsp.done)
                begin
                    p_next     = alu_rsp.result;
                    q_next     = ssub(ONE_Q, s_reg);
                    state_next = FS_SIGN;
                end
            end
            FS_QQ:
            begin
                if (alu_rsp.done)
                begin
                    qq_next    = alu_rsp.result;
                    state_next = FS_RR;
                end
            end
            FS_RR:
            begin
                if (alu_rsp.done)
                begin
                    r_next     = alu_rsp.result;
                    state_next = FS_T1A;
                end
            end
            FS_T1A:
            begin
                if (alu_rsp.done)
                begin
                    t1_next    = alu_rsp.result;
                    state_next = FS_T1B;
                end
            end
            FS_T1B:
            begin
                if (alu_rsp.done)
                begin
                    t1_next    = alu_rsp.result;
                    state_next = FS_T2;
                end
            end
            FS_T2:
            begin
                if (alu_rsp.done)
                begin
                    t2_next    = alu_rsp.result;
                    state_next = FS_PP;
                end
            end
            FS_PP:
            begin
                if (alu_rsp.done)
                begin
                    p_next     = alu_rsp.result;
                    state_next = FS_QA;
                end
            end
            FS_QA:
            begin
                if (alu_rsp.done)
                begin
                    q_next     = alu_rsp.result;
                    state_next = FS_QB;
                end
            end
            FS_QB:
            begin
                if (alu_rsp.done)
                begin
                    q_next     = alu_rsp.result;
                    state_next = FS_SIGN;
                end
            end
            FS_SIGN:
            begin
                // make p non-negative, shift the step history
                if (!p_reg[63] && p_reg != '0)
                    q_next = sneg(q_reg);
                else
                    p_next = sneg(p_reg);
                saved_next = e_reg;
                e_next     = d_reg;
                state_next = FS_C1;
            end
            FS_C1:
            begin
                if (alu_rsp.done)
                begin
                    t1_next    = alu_rsp.result;
                    state_next = FS_C2;
                end
            end
            FS_C2:
            begin
                if (alu_rsp.done)
                begin
                    t1_next    = ssub(t1_reg, sabs(alu_rsp.result));
                    state_next = FS_C3;
                end
            end
            FS_C3:
            begin
                if (alu_rsp.done)
                begin
                    // accept the interpolation only inside both bounds
                    if (sadd(p_reg, p_reg) < t1_reg && p_reg < sabs(alu_rsp.result))
                    begin
                        state_next = FS_DIVD;
                    end
                    else
                    begin
                        d_next     = m_reg;
                        e_next     = m_reg;
                        state_next = FS_STEP;
                    end
                end
            end
            FS_DIVD:
            begin
                if (alu_rsp.done)
                begin
                    d_next     = alu_rsp.result;
                    state_next = FS_STEP;
                end
            end
            FS_STEP:
            begin
                a_next  = b_reg;
                fa_next = fb_reg;
                if (sabs(d_reg) > tol_reg)
                    b_next = sadd(b_reg, d_reg);
                else if (!m_reg[63] && m_reg != '0)
                    b_next = sadd(b_reg, tol_reg);
                else
                    b_next = ssub(b_reg, tol_reg);
                res_pt_next = b_next;
                res_st_next = ST_EVALUATE;
                phase_next  = PH_WAIT;
                state_next  = FS_EMIT;
            end
            FS_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pt_next    = res_pt_reg;
                    out_st_next    = res_st_reg;
                    state_next     = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            a_reg         <= '0;
            fa_reg        <= '0;
            b_reg         <= '0;
            fb_reg        <= '0;
            c_reg         <= '0;
            fc_reg        <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            cnt_reg       <= '0;
            phase_reg     <= PH_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            issued_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            fa_reg        <= fa_next;
            b_reg         <= b_next;
            fb_reg        <= fb_next;
            c_reg         <= c_next;
            fc_reg        <= fc_next;
            d_reg         <= d_next;
            e_reg         <= e_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            issued_reg    <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        tol_reg    <= tol_next;
        s_reg      <= s_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        qq_reg     <= qq_next;
        r_reg      <= r_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        saved_reg  <= saved_next;
        res_pt_reg <= res_pt_next;
        res_st_reg <= res_st_next;
        out_pt_reg <= out_pt_next;
        out_st_reg <= out_st_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.query_point = out_pt_reg;
    assign out_ch.status      = out_st_reg;

    //------------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------------
    a_done_only_when_issued: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> issued_reg)
        else $error("shared unit finished without a pending operation");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken again before the beat was answered");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == FS_EMIT))
        else $error("result beat raised outside the emit step");

    a_no_issue_outside_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_IDLE || state_reg == FS_EMIT) |-> !issued_reg)
        else $error("operation left pending at the end of a step");

endmodule
`default_nettype wire

FILE: tb/sv/bracketed_root_finder_tb.sv
`default_nettype none
module bracketed_root_finder_tb;
    import brf_pkg::*;

    // clock, reset and channels
    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    wire logic [31:0] prdata;
    wire logic pready;

    brf_in_if in_ch();
    brf_out_if out_ch();

    bracketed_root_finder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // one expected answer per accepted input beat
    typedef struct {
        q_t         point;
        logic [1:0] status;
    } answer_t;

    answer_t pending_answers[$];
    int unsigned mismatches;
    bit quiet;    // set near the end: no idling on either side

    // search model: configuration and bracket state
    logic [31:0] cfg_abs_tol;
    logic [31:0] cfg_rel_tol;
    logic [15:0] cfg_max_steps;
    q_t br_a, br_fa, br_b, br_fb, br_c, br_fc, br_d, br_e;
    count_t br_steps;
    logic [1:0] br_phase;

    // ---------------------------------------------------------------
    // saturating Q32.32 arithmetic
    // ---------------------------------------------------------------
    function automatic logic [63:0] fx_mag(input q_t x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic q_t fx_from_mag(input logic [63:0] u, input logic neg, input logic ovf);
        if (neg)
            return (ovf || u[63]) ? Q_MIN : q_t'(64'd0 - u);
        return (ovf || u[63]) ? Q_MAX : q_t'(u);
    endfunction

    function automatic q_t fx_add(input q_t x, input q_t y);
        logic signed [64:0] s;
        s = $signed({x[63], x}) + $signed({y[63], y});
        if (s > $signed({1'b0, Q_MAX}))
            return Q_MAX;
        if (s < $signed({1'b1, Q_MIN}))
            return Q_MIN;
        return s[63:0];
    endfunction

    function automatic q_t fx_sub(input q_t x, input q_t y);
        logic signed [64:0] s;
        s = $signed({x[63], x}) - $signed({y[63], y});
        if (s > $signed({1'b0, Q_MAX}))
            return Q_MAX;
        if (s < $signed({1'b1, Q_MIN}))
            return Q_MIN;
        return s[63:0];
    endfunction

    function automatic q_t fx_neg(input q_t x);
        return (x == Q_MIN) ? Q_MAX : -x;
    endfunction

    function automatic q_t fx_abs(input q_t x);
        return x[63] ? fx_neg(x) : x;
    endfunction

    function automatic q_t fx_half(input q_t x);
        return fx_from_mag(fx_mag(x) >> 1, x[63], 1'b0);
    endfunction

    // exact product, round half away from zero
    function automatic q_t fx_mul(input q_t x, input q_t y);
        logic [127:0] full;
        full = {64'd0, fx_mag(x)} * {64'd0, fx_mag(y)} + (128'd1 << (FRAC_BITS - 1));
        return fx_from_mag(full[95:32], x[63] ^ y[63], |full[127:96]);
    endfunction

    // quotient truncated toward zero, saturating
    function automatic q_t fx_div(input q_t x, input q_t y);
        logic [95:0] quo;
        logic [63:0] ux;
        logic [63:0] uy;
        logic neg;
        if (y == 0)
            return (x == 0) ? q_t'(0) : (x[63] ? Q_MIN : Q_MAX);
        ux = fx_mag(x);
        uy = fx_mag(y);
        neg = x[63] ^ y[63];
        if ((ux >> 32) >= uy)
            return fx_from_mag(64'd0, neg, 1'b1);
        quo = {ux, 32'd0} / {32'd0, uy};
        return fx_from_mag(quo[63:0], neg, 1'b0);
    endfunction

    // ---------------------------------------------------------------
    // Brent step prediction
    // ---------------------------------------------------------------
    task automatic swap_toward_best();
        if (fx_abs(br_fc) < fx_abs(br_fb)) begin
            br_a = br_b; br_fa = br_fb;
            br_b = br_c; br_fb = br_fc;
            br_c = br_a; br_fc = br_fa;
        end
    endtask

    task automatic advance_query(input q_t m, input q_t tol);
        q_t s, p, q, qq, r, t1, t2, saved;
        if (fx_abs(br_e) < tol || fx_abs(br_fa) <= fx_abs(br_fb)) begin
            br_d = m;
            br_e = m;
        end
        else begin
            s = fx_div(br_fb, br_fa);
            if (br_a == br_c) begin
                // secant step
                p = fx_mul(fx_add(m, m), s);
                q = fx_sub(ONE_Q, s);
            end
            else begin
                // inverse quadratic step
                qq = fx_div(br_fa, br_fc);
                r = fx_div(br_fb, br_fc);
                t1 = fx_mul(fx_mul(fx_add(m, m), qq), fx_sub(qq, r));
                t2 = fx_mul(fx_sub(br_b, br_a), fx_sub(r, ONE_Q));
                p = fx_mul(s, fx_sub(t1, t2));
                q = fx_mul(fx_mul(fx_sub(qq, ONE_Q), fx_sub(r, ONE_Q)), fx_sub(s, ONE_Q));
            end
            if (p > 0)
                q = fx_neg(q);
            else
                p = fx_neg(p);
            saved = br_e;
            br_e = br_d;
            if (fx_add(p, p) < fx_sub(fx_mul(fx_add(fx_add(m, m), m), q), fx_abs(fx_mul(tol, q)))
                && p < fx_abs(fx_mul(fx_half(saved), q)))
                br_d = fx_div(p, q);
            else begin
                br_d = m;
                br_e = m;
            end
        end
        br_a = br_b;
        br_fa = br_fb;
        if (fx_abs(br_d) > tol)
            br_b = fx_add(br_b, br_d);
        else if (m > 0)
            br_b = fx_add(br_b, tol);
        else
            br_b = fx_sub(br_b, tol);
    endtask

    task automatic converge_or_query(output answer_t ans);
        q_t ab, m, tol;
        ab = fx_abs(br_b);
        m = fx_half(fx_sub(br_c, br_b));
        tol = fx_add(fx_mul(fx_add(ab, ab), q_t'({32'd0, cfg_rel_tol})),
                     q_t'({32'd0, cfg_abs_tol}));
        if (fx_abs(m) <= tol || br_fb == 0) begin
            ans.point = br_b;
            ans.status = ST_CONVERGED;
            br_phase = PH_IDLE;
        end
        else begin
            advance_query(m, tol);
            ans.point = br_b;
            ans.status = ST_EVALUATE;
            br_phase = PH_WAIT;
        end
    endtask

    task automatic predict_answer(input logic [1:0] mode, input q_t pt, input q_t fv,
                                  output answer_t ans);
        ans.point = '0;
        ans.status = ST_LOADED;
        if (mode == MODE_LOWER) begin
            br_a = pt;
            br_fa = fv;
            br_phase = PH_LOWER;
        end
        else if (mode == MODE_UPPER) begin
            br_b = pt;
            br_fb = fv;
            br_c = br_a;
            br_fc = br_fa;
            br_steps = 1;
            swap_toward_best();
            br_d = fx_sub(br_b, br_a);
            br_e = br_d;
            converge_or_query(ans);
        end
        else if (mode == MODE_VALUE && br_phase == PH_WAIT) begin
            br_fb = fv;
            // new value agrees in sign with the far end: restart bracket from a
            if ((br_fb > 0 && br_fc > 0) || (br_fb < 0 && br_fc < 0)) begin
                br_c = br_a;
                br_fc = br_fa;
                br_d = fx_sub(br_b, br_a);
                br_e = br_d;
            end
            swap_toward_best();
            if (br_steps >= count_t'(cfg_max_steps) || br_steps == COUNT_MAX) begin
                ans.point = br_b;
                ans.status = ST_LIMIT;
                br_phase = PH_IDLE;
            end
            else begin
                br_steps = br_steps + 1'b1;
                converge_or_query(ans);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // clock, reset, watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // result side: random stalls, compare each beat with oldest answer
    // ---------------------------------------------------------------
    initial
    begin
        answer_t want;
        int stall;
        out_ch.ready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: point %h status %0d",
                                 out_ch.query_point, out_ch.status);
                end
                else begin
                    want = pending_answers.pop_front();
                    if (want.point !== out_ch.query_point || want.status !== out_ch.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected point %h status %0d, got %h %0d",
                                     want.point, want.status, out_ch.query_point, out_ch.status);
                    end
                end
            end
            // now and then drop ready for a burst of random length, otherwise hold it high
            if (stall > 0)
                stall--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 6);
            out_ch.ready <= (stall == 0);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    int unsigned beats_sent;

    task automatic send_beat(input logic [1:0] mode, input q_t pt, input q_t fv,
                             input bit typed, input answer_t typed_ans);
        answer_t ans;
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_answer(mode, pt, fv, ans);
        pending_answers.push_back(typed ? typed_ans : ans);
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.point <= pt;
        in_ch.func_value <= fv;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_ABS_TOL)
            cfg_abs_tol = value;
        else if (index == REG_REL_TOL)
            cfg_rel_tol = value;
        else
            cfg_max_steps = value[15:0];
    endtask

    // hold off until every answer has come and the engine has settled
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic q_t rand_q();
        return q_t'({$urandom, $urandom});
    endfunction

    // test function: k*(x-r) + c*(x-r)^3, same sign on k and c keeps one root
    function automatic q_t probe_fn(input q_t x, input q_t r, input q_t k, input q_t c);
        q_t dx;
        dx = fx_sub(x, r);
        return fx_add(fx_mul(dx, k), fx_mul(fx_mul(dx, dx), fx_mul(dx, c)));
    endfunction

    task automatic run_search();
        q_t root, k, c, lo, hi, tmp;
        int evals;
        int cap;
        answer_t none;
        none = '{default: '0};
        root = q_t'($signed({{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom}));
        k = q_t'({30'd0, 2'($urandom), $urandom}) + 1;
        c = q_t'({44'd0, 20'($urandom)});
        if ($urandom_range(0, 1)) begin
            k = -k;
            c = -c;
        end
        lo = fx_sub(root, q_t'({18'd0, 14'($urandom), $urandom}) + 1);
        hi = fx_add(root, q_t'({18'd0, 14'($urandom), $urandom}) + 1);
        // mostly a proper bracket; sometimes swapped, same-sign or no lower load
        case ($urandom_range(0, 9))
            0: begin tmp = lo; lo = hi; hi = tmp; end
            1: hi = fx_sub(lo, q_t'({32'd0, $urandom}));
            default: ;
        endcase
        if ($urandom_range(0, 19) != 0)
            send_beat(MODE_LOWER, lo, probe_fn(lo, root, k, c), 1'b0, none);
        send_beat(MODE_UPPER, hi, probe_fn(hi, root, k, c), 1'b0, none);
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 40;
        evals = 0;
        while (br_phase == PH_WAIT && evals < cap)
        begin
            send_beat(MODE_VALUE, rand_q(), probe_fn(br_b, root, k, c), 1'b0, none);
            evals++;
        end
    endtask

    typedef struct {
        logic [1:0] mode;
        q_t         pt;
        q_t         fv;
        bit         typed;
        answer_t    ans;
    } stim_row_t;

    initial
    begin
        stim_row_t rows[$];
        answer_t loaded;
        answer_t none;
        int pick;
        int phase_no;

        loaded = '{point: '0, status: ST_LOADED};
        none = loaded;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_LOWER;
        in_ch.point = '0;
        in_ch.func_value = '0;
        quiet = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        cfg_abs_tol = 32'd4295;
        cfg_rel_tol = 32'd1;
        cfg_max_steps = 16'd100;
        br_a = '0; br_fa = '0; br_b = '0; br_fb = '0;
        br_c = '0; br_fc = '0; br_d = '0; br_e = '0;
        br_steps = '0;
        br_phase = PH_IDLE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset configuration
        rows.push_back('{MODE_VALUE, Q_MAX, Q_MIN, 1'b1, loaded});   // value outside a search
        rows.push_back('{2'd3, Q_MAX, Q_MIN, 1'b1, loaded});         // unused mode
        rows.push_back('{MODE_LOWER, Q_MIN, Q_MAX, 1'b1, loaded});
        rows.push_back('{MODE_UPPER, Q_MAX, '0, 1'b1,                // root right on upper bound
                         '{point: Q_MAX, status: ST_CONVERGED}});
        rows.push_back('{MODE_UPPER, '0, Q_MIN, 1'b0, none});        // start reusing old bracket end
        rows.push_back('{MODE_VALUE, '0, Q_MAX, 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, Q_MIN, 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, 64'sh1, 1'b0, none});
        rows.push_back('{MODE_LOWER, -ONE_Q, -ONE_Q, 1'b1, loaded});
        rows.push_back('{MODE_UPPER, 3 * ONE_Q, 3 * ONE_Q, 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, ONE_Q / 2, 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, -(ONE_Q / 4), 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, ONE_Q / 16, 1'b0, none});
        rows.push_back('{MODE_VALUE, '0, '0, 1'b0, none});
        rows.push_back('{MODE_LOWER, '0, '0, 1'b1, loaded});
        rows.push_back('{MODE_UPPER, '0, 5 * ONE_Q, 1'b1,            // zero at lower bound wins
                         '{point: '0, status: ST_CONVERGED}});
        foreach (rows[i])
            send_beat(rows[i].mode, rows[i].pt, rows[i].fv, rows[i].typed, rows[i].ans);

        // random searches over four configurations: the reset one, two extremes, then a random one
        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            drain();
            case (phase_no)
                0: ;
                1: begin
                    apb_write(REG_ABS_TOL, 32'd0);
                    apb_write(REG_REL_TOL, 32'd0);
                    apb_write(REG_MAX_STEPS, 16'hFFFF);
                end
                2: begin
                    apb_write(REG_ABS_TOL, 32'hFFFF_FFFF);
                    apb_write(REG_REL_TOL, 32'hFFFF_FFFF);
                    apb_write(REG_MAX_STEPS, 16'd1);
                end
                default: begin
                    apb_write(REG_ABS_TOL, $urandom_range(1, 1 << 20));
                    apb_write(REG_REL_TOL, $urandom_range(0, 1 << 12));
                    apb_write(REG_MAX_STEPS, $urandom_range(2, 30));
                end
            endcase
            while (beats_sent < 16 + 250 * (phase_no + 1))
            begin
                quiet = (beats_sent > 880);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_beat(2'($urandom), rand_q(), rand_q(), 1'b0, none);
                else
                    run_search();
            end
        end

        drain();
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
design/brf_pkg.sv
design/brf_channels.sv
design/brf_alu.sv
design/bracketed_root_finder.sv
tb/sv/bracketed_root_finder_tb.sv
